### src/tcp_option_parser_top_assert.svh
// ----------------------------------------------------------------------------
// tcp_option_parser_top_assert.svh
// Assertion macros for the TCP option parser.
// ----------------------------------------------------------------------------
`ifndef TCP_OPTION_PARSER_TOP_ASSERT_SVH
`define TCP_OPTION_PARSER_TOP_ASSERT_SVH

// check cons in the same cycle as ante
`define TOPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define TOPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/topt_pkg.sv
// ----------------------------------------------------------------------------
// topt_pkg
// Types and constants shared by the TCP option parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package topt_pkg;

  localparam int MAX_OPTION_BYTES_DEF = 40;
  localparam logic [15:0] DEFAULT_MSS_RST = 16'd1460;

  localparam logic [7:0] KIND_EOL  = 8'd0;
  localparam logic [7:0] KIND_NOP  = 8'd1;
  localparam logic [7:0] KIND_MSS  = 8'd2;
  localparam logic [7:0] KIND_SACK = 8'd4;
  localparam logic [7:0] KIND_TS   = 8'd8;

  localparam logic [7:0] MIN_LEN   = 8'd2;
  localparam logic [7:0] MSS_BODY  = 8'd2;
  localparam logic [7:0] SACK_BODY = 8'd0;
  localparam logic [7:0] TS_BODY   = 8'd8;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       last_byte;
  } topt_in_t;

  typedef struct packed {
    logic [15:0] mss_value;
    logic        sack_permitted;
    logic        timestamp_seen;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic        malformed;
  } topt_out_t;

  typedef struct packed {
    logic     consume;
    topt_in_t item;
  } topt_stage_t;

endpackage

`default_nettype wire

### src/tcp_option_parser_top.sv
// ----------------------------------------------------------------------------
// tcp_option_parser_top
// A last byte passes the input register, then its result is registered.
// Throughput: one byte per cycle when not stalled; single parse-state update.
// Reset: synchronous active-low rst_n clears parse state, empties both stages
// and loads default_mss with 1460.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_option_parser_top import topt_pkg::*; #(
  parameter int MAX_OPTION_BYTES = MAX_OPTION_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire topt_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output topt_out_t        out_data,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic        out_valid_r, out_valid_nxt;
  topt_out_t   out_data_r;
  logic [15:0] default_mss_r;
  logic        out_free;
  logic        emit;
  topt_stage_t stage;
  topt_out_t   result;

  assign out_free = ~out_valid_r | ~out_stall;
  assign emit     = stage.consume & stage.item.last_byte;

  topt_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_free (out_free),
    .stage    (stage)
  );

  topt_parse_core #(
    .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
  ) u_parse_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (stage),
    .default_mss (default_mss_r),
    .result      (result)
  );

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      default_mss_r <= DEFAULT_MSS_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        default_mss_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "tcp_option_parser_top_assert.svh"

  `TOPT_ASSERT_NEXT(a_emit_shows, clk, rst_n, emit, out_valid, "last byte gave no result")
  `TOPT_ASSERT_NEXT(a_drain_clears, clk, rst_n, out_valid && !out_stall && !emit, !out_valid, "result repeated")
  `TOPT_ASSERT_SAME(a_ts_zero, clk, rst_n, out_valid && !out_data.timestamp_seen, out_data.ts_value == 32'd0 && out_data.ts_echo == 32'd0, "timestamp words not cleared")
  `TOPT_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled with free output")

endmodule

`default_nettype wire

### src/topt_in_stage.sv
// ----------------------------------------------------------------------------
// topt_in_stage
// Input register for option bytes; releases a request to the parser core.
// ----------------------------------------------------------------------------
`default_nettype none

module topt_in_stage import topt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire topt_in_t    in_data,
  input  wire logic        out_free,
  output topt_stage_t      stage
);

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  topt_in_t s1_item_r;
  logic     go;
  logic     load;

  assign go       = s1_valid_r & (~s1_item_r.last_byte | out_free);
  assign in_stall = s1_valid_r & ~go;
  assign load     = in_valid & ~in_stall;

  always_comb begin
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= in_data;
    end
  end

  assign stage.consume = go;
  assign stage.item    = s1_item_r;

endmodule

`default_nettype wire

### src/topt_parse_core.sv
// ----------------------------------------------------------------------------
// topt_parse_core
// Per-area option parse state; forms the result on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module topt_parse_core import topt_pkg::*; #(
  parameter int MAX_OPTION_BYTES = MAX_OPTION_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire topt_stage_t stage,
  input  wire logic [15:0] default_mss,
  output topt_out_t        result
);

  localparam int CNT_W = $clog2(MAX_OPTION_BYTES + 1);

  typedef enum logic [1:0] {
    PH_KIND,
    PH_LEN,
    PH_BODY,
    PH_ENDED
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [7:0]   left_r, left_nxt;
  logic [7:0]   kind_r, kind_nxt;
  logic [15:0]  mss_acc_r, mss_acc_nxt;
  logic [63:0]  ts_acc_r, ts_acc_nxt;
  logic         sack_r, sack_nxt;
  logic         ts_r, ts_nxt;
  logic         mss_r, mss_nxt;
  logic         err_r, err_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]   b;
  logic [7:0]   left_len;
  logic         err_fin;

  assign b = stage.item.option_byte;

  always_comb begin
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    kind_nxt    = kind_r;
    mss_acc_nxt = mss_acc_r;
    ts_acc_nxt  = ts_acc_r;
    sack_nxt    = sack_r;
    ts_nxt      = ts_r;
    mss_nxt     = mss_r;
    err_nxt     = err_r;
    cnt_nxt     = cnt_r;
    left_len    = 8'd0;
    err_fin     = 1'b0;
    result      = '0;

    if (stage.consume) begin
      if (cnt_r == CNT_W'(MAX_OPTION_BYTES)) begin
        err_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_KIND: begin
            kind_nxt = b;
            if (b == KIND_EOL) begin
              phase_nxt = PH_ENDED;
            end else if (b == KIND_NOP) begin
              phase_nxt = PH_KIND;
            end else begin
              if (b == KIND_MSS) mss_nxt = 1'b0;
              if (b == KIND_TS) ts_nxt = 1'b0;
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            if (kind_r == KIND_MSS) begin
              left_len = MSS_BODY;
            end else if (kind_r == KIND_SACK) begin
              left_len = SACK_BODY;
            end else if (kind_r == KIND_TS) begin
              left_len = TS_BODY;
            end else begin
              left_len = b - MIN_LEN;
            end
            if (kind_r != KIND_MSS && kind_r != KIND_SACK && kind_r != KIND_TS &&
                b < MIN_LEN) begin
              err_nxt   = 1'b1;
              phase_nxt = PH_ENDED;
            end else begin
              left_nxt = left_len;
              if (left_len == 8'd0) begin
                if (kind_r == KIND_MSS) mss_nxt = 1'b1;
                if (kind_r == KIND_SACK) sack_nxt = 1'b1;
                if (kind_r == KIND_TS) ts_nxt = 1'b1;
                phase_nxt = PH_KIND;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
          PH_BODY: begin
            if (kind_r == KIND_MSS) mss_acc_nxt = {mss_acc_r[7:0], b};
            if (kind_r == KIND_TS) ts_acc_nxt = {ts_acc_r[55:0], b};
            left_nxt = left_r - 8'd1;
            if (left_r == 8'd1) begin
              if (kind_r == KIND_MSS) mss_nxt = 1'b1;
              if (kind_r == KIND_SACK) sack_nxt = 1'b1;
              if (kind_r == KIND_TS) ts_nxt = 1'b1;
              phase_nxt = PH_KIND;
            end
          end
          PH_ENDED: begin
            phase_nxt = PH_ENDED;
          end
          default: begin
            phase_nxt = PH_ENDED;
          end
        endcase
      end

      if (cnt_r != CNT_W'(MAX_OPTION_BYTES)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end

      if (stage.item.last_byte) begin
        err_fin = err_nxt | (phase_nxt == PH_LEN) | (phase_nxt == PH_BODY);
        result.mss_value      = mss_nxt ? mss_acc_nxt : default_mss;
        result.sack_permitted = sack_nxt;
        result.timestamp_seen = ts_nxt;
        result.ts_value       = ts_nxt ? ts_acc_nxt[63:32] : 32'd0;
        result.ts_echo        = ts_nxt ? ts_acc_nxt[31:0] : 32'd0;
        result.malformed      = err_fin;
        phase_nxt = PH_KIND;
        left_nxt  = 8'd0;
        kind_nxt  = 8'd0;
        sack_nxt  = 1'b0;
        ts_nxt    = 1'b0;
        mss_nxt   = 1'b0;
        err_nxt   = 1'b0;
        cnt_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_KIND;
      left_r    <= 8'd0;
      kind_r    <= 8'd0;
      mss_acc_r <= DEFAULT_MSS_RST;
      ts_acc_r  <= '0;
      sack_r    <= 1'b0;
      ts_r      <= 1'b0;
      mss_r     <= 1'b0;
      err_r     <= 1'b0;
      cnt_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      left_r    <= left_nxt;
      kind_r    <= kind_nxt;
      mss_acc_r <= mss_acc_nxt;
      ts_acc_r  <= ts_acc_nxt;
      sack_r    <= sack_nxt;
      ts_r      <= ts_nxt;
      mss_r     <= mss_nxt;
      err_r     <= err_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire
